// ===== rtl/u8dec_pkg.sv =====
// ============================================================================
// u8dec_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ============================================================================
package u8dec_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned LEN_W = 3;
    localparam int unsigned ERR_W = 2;
    localparam int unsigned PAY_W = 7;

    // Error codes carried in error_kind
    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_LEAD  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_CONT  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED = 2'd3;

    // Sequence lengths
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    // Byte classes decided by the front end
    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_CONT,
        CLS_BAD
    } t_byte_cls;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       buffer_end;
    } t_in_beat;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        logic [ERR_W-1:0] error_kind;
    } t_out_beat;

    // One classified byte as held in the queue
    typedef struct packed {
        t_byte_cls        cls;
        logic [PAY_W-1:0] payload;
        logic             last;
    } t_cls_beat;

endpackage

// ===== rtl/u8dec_front.sv =====
// ============================================================================
// u8dec_front
// Classifies each incoming byte and strips its marker bits.
// ============================================================================
module u8dec_front
    import u8dec_pkg::*;
(
    input  t_in_beat  i_beat,
    output t_cls_beat o_cls_beat
);

    always_comb begin
        o_cls_beat.last    = i_beat.buffer_end;
        o_cls_beat.payload = '0;
        if (i_beat.in_byte[7] == 1'b0) begin
            o_cls_beat.cls     = CLS_ASCII;
            o_cls_beat.payload = i_beat.in_byte[6:0];
        end else if (i_beat.in_byte[7:6] == 2'b10) begin
            o_cls_beat.cls     = CLS_CONT;
            o_cls_beat.payload = {1'b0, i_beat.in_byte[5:0]};
        end else if (i_beat.in_byte[7:5] == 3'b110) begin
            o_cls_beat.cls     = CLS_LEAD2;
            o_cls_beat.payload = {2'b00, i_beat.in_byte[4:0]};
        end else if (i_beat.in_byte[7:4] == 4'b1110) begin
            o_cls_beat.cls     = CLS_LEAD3;
            o_cls_beat.payload = {3'b000, i_beat.in_byte[3:0]};
        end else if (i_beat.in_byte[7:3] == 5'b11110) begin
            o_cls_beat.cls     = CLS_LEAD4;
            o_cls_beat.payload = {4'b0000, i_beat.in_byte[2:0]};
        end else begin
            o_cls_beat.cls     = CLS_BAD;
        end
    end

endmodule

// ===== rtl/u8dec_queue.sv =====
// ============================================================================
// u8dec_queue
// Short register FIFO of classified bytes between front and back end.
// ============================================================================
module u8dec_queue
    import u8dec_pkg::*;
#(
    parameter int unsigned P_DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cls_beat i_push_beat,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_not_empty,
    output t_cls_beat o_head
);

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(P_DEPTH);

    t_cls_beat        r_slot [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full      = (r_count == FULL_CNT);
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_beat;
        end
    end

endmodule

// ===== rtl/u8dec_back.sv =====
// ============================================================================
// u8dec_back
// Sequence state, accumulator and the result register.
// ============================================================================
module u8dec_back
    import u8dec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_cls_beat i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    logic [CP_W-1:0]  r_acc, n_acc;
    logic [1:0]       r_pend, n_pend;
    logic [LEN_W-1:0] r_size, n_size;
    logic             r_out_valid, n_out_valid;
    t_out_beat        r_out_beat, n_out_beat;

    logic             res_valid;
    t_out_beat        res_beat;
    logic [CP_W-1:0]  shifted;
    logic             can_load;

    assign can_load    = !r_out_valid || !i_out_stall;
    assign o_pop       = i_head_valid && can_load;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;
    assign shifted     = {r_acc[CP_W-7:0], i_head.payload[5:0]};

    always_comb begin
        n_acc     = r_acc;
        n_pend    = r_pend;
        n_size    = r_size;
        res_valid = 1'b0;
        res_beat  = '{code_point: '0, seq_length: '0, error_kind: ERR_NONE};
        if (o_pop) begin
            if (r_pend == 2'd0) begin
                unique case (i_head.cls) inside
                    CLS_ASCII: begin
                        res_valid           = 1'b1;
                        res_beat.code_point = CP_W'(i_head.payload);
                        res_beat.seq_length = LEN_ONE;
                    end
                    CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
                        if (i_head.last) begin
                            res_valid           = 1'b1;
                            res_beat.error_kind = ERR_TRUNCATED;
                        end else begin
                            n_acc = CP_W'(i_head.payload);
                            unique case (i_head.cls)
                                CLS_LEAD2: begin
                                    n_pend = 2'd1;
                                    n_size = LEN_TWO;
                                end
                                CLS_LEAD3: begin
                                    n_pend = 2'd2;
                                    n_size = LEN_THREE;
                                end
                                default: begin
                                    n_pend = 2'd3;
                                    n_size = LEN_FOUR;
                                end
                            endcase
                        end
                    end
                    default: begin
                        res_valid           = 1'b1;
                        res_beat.error_kind = ERR_BAD_LEAD;
                    end
                endcase
            end else if (i_head.cls != CLS_CONT) begin
                res_valid           = 1'b1;
                res_beat.error_kind = ERR_BAD_CONT;
                n_acc  = '0;
                n_pend = 2'd0;
                n_size = '0;
            end else if (r_pend == 2'd1) begin
                res_valid           = 1'b1;
                res_beat.code_point = shifted;
                res_beat.seq_length = r_size;
                n_acc  = '0;
                n_pend = 2'd0;
                n_size = '0;
            end else if (i_head.last) begin
                res_valid           = 1'b1;
                res_beat.error_kind = ERR_TRUNCATED;
                n_acc  = '0;
                n_pend = 2'd0;
                n_size = '0;
            end else begin
                n_acc  = shifted;
                n_pend = r_pend - 2'd1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_beat  = r_out_beat;
        if (can_load) begin
            n_out_valid = res_valid;
            if (res_valid) begin
                n_out_beat = res_beat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_pend      <= 2'd0;
            r_size      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_pend      <= n_pend;
            r_size      <= n_size;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_beat <= n_out_beat;
    end

endmodule

// ===== rtl/utf8_stream_decoder_unit.sv =====
// ============================================================================
// utf8_stream_decoder_unit
// Streaming UTF-8 decoder: one byte in, zero or one scalar result out.
// ============================================================================
//
//  Channel | Direction | Handshake                  | Beat
//  --------+-----------+----------------------------+------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_beat  (t_in_beat)
//  out     | output    | o_out_valid / i_out_stall  | o_out_beat (t_out_beat)
//
//  One byte per cycle sustained while i_out_stall does not hold the result
//  register. An accepted byte is written into a queue slot and decoded from
//  there into the result register. The queue holds P_QUEUE_DEPTH classified
//  bytes; o_in_stall rises only when it is full, i.e. when i_out_stall has
//  been holding the result register. Reset is synchronous and leaves the
//  block idle with an empty queue and no pending result.
//
// Front end: classify the byte (ASCII, lead of 2/3/4, continuation, bad lead)
// and strip its marker bits. The queue decouples it from the back end, which
// owns the sequence state and the result register.
// ============================================================================
module utf8_stream_decoder_unit
    import u8dec_pkg::*;
#(
    parameter int unsigned P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    t_cls_beat cls_beat;
    t_cls_beat head;
    logic      q_full;
    logic      q_not_empty;
    logic      pop;
    logic      push;

    // Take a beat whenever the queue has room
    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    u8dec_front u_front (
        .i_beat     (i_in_beat),
        .o_cls_beat (cls_beat)
    );

    u8dec_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_beat (cls_beat),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_head      (head)
    );

    // Advance the sequence state and load the result register
    u8dec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_not_empty),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_beat   (o_out_beat)
    );

endmodule

// ===== rtl/u8dec_checker.sv =====
// ============================================================================
// u8dec_checker
// Port-level checks on the UTF-8 stream decoder, bound to the top level.
// ============================================================================
module u8dec_checker
    import u8dec_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in_beat,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_beat
);

    // A held result stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.error_kind != ERR_NONE) |->
            (o_out_beat.code_point == '0) && (o_out_beat.seq_length == '0))
        else $error("error result carries data");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.error_kind == ERR_NONE) |->
            (o_out_beat.seq_length != '0) && (o_out_beat.seq_length <= LEN_FOUR))
        else $error("good result with bad length");

    a_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.error_kind == ERR_NONE)
            && (o_out_beat.seq_length == LEN_ONE) |->
            (o_out_beat.code_point[CP_W-1:7] == '0))
        else $error("one-byte result above 0x7f");

    // A stalled input beat is held steady by the sender
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_beat))
        else $error("input beat changed while stalled");

    a_in_stall_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_in_stall && !o_out_valid)
        else $error("block not idle after reset");

endmodule

bind utf8_stream_decoder_unit u8dec_checker u_u8dec_checker (.*);
